// File: hw/rtl/graph_degree_leaf_table_core_defines.svh
// assertion helpers for the degree and leaf table
// every use needs clk and arst_n in scope
`ifndef GRAPH_DEGREE_LEAF_TABLE_CORE_DEFINES_SVH
`define GRAPH_DEGREE_LEAF_TABLE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define GDLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define GDLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gdlt_pkg.sv
`timescale 1ns / 1ps

package gdlt_pkg;

	localparam int BUS_COUNT   = 32;
	localparam int MAX_RESULTS = 32;

	localparam int BUS_W  = 6;
	localparam int DEG_W  = 6;
	localparam int EDGE_W = 11;
	localparam int LEAF_W = 6;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_QUERY  = 2'd1,
		OP_REPORT = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_B,
		S_ADD_W,
		S_QRY,
		S_NONE,
		S_RPT
	} state_t;

endpackage

// File: hw/rtl/gdlt_if.sv
`timescale 1ns / 1ps

// command channel
interface gdlt_cmd_if;
	logic                        valid;
	logic                        ready;
	gdlt_pkg::op_t               operation;
	logic [gdlt_pkg::BUS_W-1:0]  from_bus;
	logic [gdlt_pkg::BUS_W-1:0]  to_bus;
	logic                        in_service;

	modport source (output valid, output operation, output from_bus, output to_bus,
		output in_service, input ready);
	modport sink (input valid, input operation, input from_bus, input to_bus,
		input in_service, output ready);
endinterface

// result channel
interface gdlt_res_if;
	logic                        valid;
	logic                        ready;
	logic [gdlt_pkg::BUS_W-1:0]  bus_number;
	logic [gdlt_pkg::DEG_W-1:0]  degree;
	logic [gdlt_pkg::EDGE_W-1:0] edge_count;
	logic [gdlt_pkg::LEAF_W-1:0] leaf_count;
	logic                        leaf_valid;
	logic                        last;

	modport source (output valid, output bus_number, output degree, output edge_count,
		output leaf_count, output leaf_valid, output last, input ready);
	modport sink (input valid, input bus_number, input degree, input edge_count,
		input leaf_count, input leaf_valid, input last, output ready);
endinterface

// File: hw/rtl/graph_degree_leaf_table_core.sv
`timescale 1ns / 1ps
// Undirected bus graph table: keeps one adjacency row and one 6-bit degree per bus
// (buses 1..BUS_COUNT) in a single RAM word, plus an edge count and a leaf count in
// flops. An add of a new branch reads the row of from_bus, writes it back while reading
// the row of to_bus, then writes that row; a duplicate add stops after the first read;
// an ignored add or a clear needs no RAM access; a query reads one entry and a report
// scans at most BUS_COUNT-1 buses; both wait on any stall on the result side. The scan
// reads one entry per cycle through the single RAM read port unless a result word stalls.
// After reset and after a clear the table is empty at once: per-bus valid flops make
// an unwritten entry read as zero, so there is no clearing pass. A report emits the
// lowest-numbered leaves (bus 2 and up, degree one), at most MAX_RESULTS of them,
// with last on the final one; an empty report gives one word with bus_number 0.
// Edge and leaf counts in a result word are those at the time of its command.

`include "graph_degree_leaf_table_core_defines.svh"

module graph_degree_leaf_table_core #(
	parameter int BUS_COUNT = gdlt_pkg::BUS_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	gdlt_cmd_if.sink    cmd,
	gdlt_res_if.source  res
);

	localparam int IDX_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
	localparam int ENT_W = BUS_COUNT + gdlt_pkg::DEG_W;
	localparam logic [BUS_COUNT-1:0] ONE_ROW = 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUS_COUNT - 1);
	localparam logic [gdlt_pkg::LEAF_W-1:0] MAX_EMIT = gdlt_pkg::LEAF_W'(gdlt_pkg::MAX_RESULTS);

	// bus number in 1..BUS_COUNT
	function automatic logic bus_ok(input logic [gdlt_pkg::BUS_W-1:0] b);
		return (b != '0) && ({1'b0, b} <= (gdlt_pkg::BUS_W + 1)'(BUS_COUNT));
	endfunction

	// state
	gdlt_pkg::state_t state_q, state_d;
	logic [BUS_COUNT-1:0]          vld_q;
	logic [gdlt_pkg::EDGE_W-1:0]   edge_q;
	logic [gdlt_pkg::LEAF_W-1:0]   leaf_q;
	logic [IDX_W-1:0]              scan_q;
	logic [gdlt_pkg::LEAF_W-1:0]   rem_q;
	logic                          rd_vld_q;

	// captured command
	logic [IDX_W-1:0]              idx_a_q, idx_b_q;
	logic                          qry_ok_q;
	logic [gdlt_pkg::BUS_W-1:0]    qry_bus_q;
	logic [gdlt_pkg::DEG_W-1:0]    deg_a_q;

	// result register
	logic                          res_vld_q;
	logic [gdlt_pkg::BUS_W-1:0]    res_bus_q;
	logic [gdlt_pkg::DEG_W-1:0]    res_deg_q;
	logic [gdlt_pkg::EDGE_W-1:0]   res_edge_q;
	logic [gdlt_pkg::LEAF_W-1:0]   res_leaf_q;
	logic                          res_leafv_q, res_last_q;

	// ram side
	logic                          ram_we, ram_re;
	logic [IDX_W-1:0]              ram_waddr, ram_raddr;
	logic [ENT_W-1:0]              ram_wdata, ram_rdata, ent;
	logic [BUS_COUNT-1:0]          ent_row;
	logic [gdlt_pkg::DEG_W-1:0]    ent_deg;

	// decode
	logic                          accept, out_free, add_ok, dup, ent_leaf;
	logic [gdlt_pkg::BUS_W-1:0]    fb_m1, tb_m1;
	logic [IDX_W-1:0]              fb_idx, tb_idx;

	// control from the output block
	logic                          do_clear, do_count, do_cap_a, do_start_rpt, do_scan;
	logic                          ld;
	logic [gdlt_pkg::BUS_W-1:0]    ld_bus;
	logic [gdlt_pkg::DEG_W-1:0]    ld_deg;
	logic                          ld_leafv, ld_last;

	// leaf count change on a new edge
	logic                          la_up, la_dn, lb_up, lb_dn;
	logic [gdlt_pkg::LEAF_W-1:0]   leaf_nx;

	gdlt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (BUS_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// entry never written since reset or clear reads as zero
	assign ent     = rd_vld_q ? ram_rdata : '0;
	assign ent_row = ent[ENT_W-1:gdlt_pkg::DEG_W];
	assign ent_deg = ent[gdlt_pkg::DEG_W-1:0];

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !res_vld_q || res.ready;

	assign fb_m1  = cmd.from_bus - gdlt_pkg::BUS_W'(1);
	assign tb_m1  = cmd.to_bus - gdlt_pkg::BUS_W'(1);
	assign fb_idx = fb_m1[IDX_W-1:0];
	assign tb_idx = tb_m1[IDX_W-1:0];
	assign add_ok = cmd.in_service && (cmd.from_bus != cmd.to_bus)
		&& bus_ok(cmd.from_bus) && bus_ok(cmd.to_bus);

	// branch already stored: row of bus a has the bit of bus b
	assign dup      = ent_row[idx_b_q];
	assign ent_leaf = (ent_deg == gdlt_pkg::DEG_W'(1));

	// bus 1 never counts as a leaf
	assign la_up = (idx_a_q != '0) && (deg_a_q == '0);
	assign la_dn = (idx_a_q != '0) && (deg_a_q == gdlt_pkg::DEG_W'(1));
	assign lb_up = (idx_b_q != '0) && (ent_deg == '0);
	assign lb_dn = (idx_b_q != '0) && (ent_deg == gdlt_pkg::DEG_W'(1));
	assign leaf_nx = leaf_q + gdlt_pkg::LEAF_W'(la_up) + gdlt_pkg::LEAF_W'(lb_up)
		- gdlt_pkg::LEAF_W'(la_dn) - gdlt_pkg::LEAF_W'(lb_dn);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gdlt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd.operation)
						gdlt_pkg::OP_ADD:    state_d = add_ok ? gdlt_pkg::S_ADD_B : gdlt_pkg::S_IDLE;
						gdlt_pkg::OP_QUERY:  state_d = gdlt_pkg::S_QRY;
						gdlt_pkg::OP_REPORT: state_d = (leaf_q == '0) ? gdlt_pkg::S_NONE
							: gdlt_pkg::S_RPT;
						gdlt_pkg::OP_CLEAR:  state_d = gdlt_pkg::S_IDLE;
						default:             state_d = gdlt_pkg::S_IDLE;
					endcase
				end
			end
			gdlt_pkg::S_ADD_B: state_d = dup ? gdlt_pkg::S_IDLE : gdlt_pkg::S_ADD_W;
			gdlt_pkg::S_ADD_W: state_d = gdlt_pkg::S_IDLE;
			gdlt_pkg::S_QRY, gdlt_pkg::S_NONE: begin
				if (out_free) begin
					state_d = gdlt_pkg::S_IDLE;
				end
			end
			gdlt_pkg::S_RPT: begin
				if (ent_leaf) begin
					// final emitted leaf, or end of the bus range
					if (out_free && ((rem_q == gdlt_pkg::LEAF_W'(1)) || (scan_q == LAST_IDX))) begin
						state_d = gdlt_pkg::S_IDLE;
					end
				end else if (scan_q == LAST_IDX) begin
					state_d = gdlt_pkg::S_IDLE;
				end
			end
			default: state_d = gdlt_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = idx_a_q;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = fb_idx;
		do_clear     = 1'b0;
		do_count     = 1'b0;
		do_cap_a     = 1'b0;
		do_start_rpt = 1'b0;
		do_scan      = 1'b0;
		ld           = 1'b0;
		ld_bus       = '0;
		ld_deg       = '0;
		ld_leafv     = 1'b0;
		ld_last      = 1'b1;
		unique case (state_q)
			gdlt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd.operation)
						gdlt_pkg::OP_ADD: begin
							ram_re    = add_ok;
							ram_raddr = fb_idx;
						end
						gdlt_pkg::OP_QUERY: begin
							ram_re    = bus_ok(cmd.from_bus);
							ram_raddr = fb_idx;
						end
						gdlt_pkg::OP_REPORT: begin
							// scan starts at bus 2
							ram_re       = (leaf_q != '0);
							ram_raddr    = IDX_W'(1);
							do_start_rpt = 1'b1;
						end
						gdlt_pkg::OP_CLEAR: do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			gdlt_pkg::S_ADD_B: begin
				do_cap_a = 1'b1;
				if (!dup) begin
					ram_we    = 1'b1;
					ram_waddr = idx_a_q;
					ram_wdata = {ent_row | (ONE_ROW << idx_b_q), ent_deg + gdlt_pkg::DEG_W'(1)};
					ram_re    = 1'b1;
					ram_raddr = idx_b_q;
				end
			end
			gdlt_pkg::S_ADD_W: begin
				ram_we    = 1'b1;
				ram_waddr = idx_b_q;
				ram_wdata = {ent_row | (ONE_ROW << idx_a_q), ent_deg + gdlt_pkg::DEG_W'(1)};
				do_count  = 1'b1;
			end
			gdlt_pkg::S_QRY: begin
				ld     = out_free;
				ld_bus = qry_ok_q ? qry_bus_q : '0;
				ld_deg = qry_ok_q ? ent_deg : '0;
			end
			gdlt_pkg::S_NONE: begin
				ld = out_free;
			end
			gdlt_pkg::S_RPT: begin
				ld_bus   = gdlt_pkg::BUS_W'(scan_q) + gdlt_pkg::BUS_W'(1);
				ld_deg   = gdlt_pkg::DEG_W'(1);
				ld_leafv = 1'b1;
				ld_last  = (rem_q == gdlt_pkg::LEAF_W'(1));
				ram_raddr = scan_q + IDX_W'(1);
				if (ent_leaf) begin
					ld = out_free;
					if (out_free && (rem_q != gdlt_pkg::LEAF_W'(1)) && (scan_q != LAST_IDX)) begin
						ram_re  = 1'b1;
						do_scan = 1'b1;
					end
				end else if (scan_q != LAST_IDX) begin
					ram_re  = 1'b1;
					do_scan = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == gdlt_pkg::S_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gdlt_pkg::S_IDLE;
			vld_q    <= '0;
			edge_q   <= '0;
			leaf_q   <= '0;
			scan_q   <= '0;
			rem_q    <= '0;
			rd_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				vld_q  <= '0;
				edge_q <= '0;
				leaf_q <= '0;
			end else if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (do_count) begin
				edge_q <= edge_q + gdlt_pkg::EDGE_W'(1);
				leaf_q <= leaf_nx;
			end
			if (ram_re) begin
				rd_vld_q <= vld_q[ram_raddr];
			end
			if (do_start_rpt) begin
				scan_q <= IDX_W'(1);
				rem_q  <= (leaf_q > MAX_EMIT) ? MAX_EMIT : leaf_q;
			end else if (do_scan) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (ld && ld_leafv) begin
				rem_q <= rem_q - gdlt_pkg::LEAF_W'(1);
			end
			if (ld) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// payload registers, counts frozen with the word so later commands cannot move them
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_a_q   <= fb_idx;
			idx_b_q   <= tb_idx;
			qry_ok_q  <= bus_ok(cmd.from_bus);
			qry_bus_q <= cmd.from_bus;
		end
		if (do_cap_a) begin
			deg_a_q <= ent_deg;
		end
		if (ld) begin
			res_bus_q   <= ld_bus;
			res_deg_q   <= ld_deg;
			res_edge_q  <= edge_q;
			res_leaf_q  <= leaf_q;
			res_leafv_q <= ld_leafv;
			res_last_q  <= ld_last;
		end
	end

	assign res.valid      = res_vld_q;
	assign res.bus_number = res_bus_q;
	assign res.degree     = res_deg_q;
	assign res.edge_count = res_edge_q;
	assign res.leaf_count = res_leaf_q;
	assign res.leaf_valid = res_leafv_q;
	assign res.last       = res_last_q;

	// the two writes of one branch go to different rows, so no forwarding is needed
	`GDLT_ASSERT_NOW(a_add_rows_distinct, state_q == gdlt_pkg::S_ADD_W, idx_a_q != idx_b_q, "branch write-back hit the same row twice")
	// every new branch adds exactly one edge
	`GDLT_ASSERT_NEXT(a_edge_step, state_q == gdlt_pkg::S_ADD_W, edge_q == $past(edge_q) + gdlt_pkg::EDGE_W'(1), "edge count did not step by one")
	// a reported leaf has degree one and the leaf count is not empty
	`GDLT_ASSERT_NOW(a_leaf_word, res_vld_q && res_leafv_q, (res_deg_q == gdlt_pkg::DEG_W'(1)) && (res_leaf_q != '0), "leaf word inconsistent with counts")

endmodule

// File: hw/rtl/gdlt_ram.sv
`timescale 1ns / 1ps

// simple dual port ram, registered read
module gdlt_ram #(
	parameter int WIDTH = gdlt_pkg::BUS_COUNT + gdlt_pkg::DEG_W,
	parameter int DEPTH = gdlt_pkg::BUS_COUNT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
